// ===== hw/rtl/stq_pkg.sv =====
// Shared types, codes and sizes for the sorted timer queue.
package stq_pkg;

  localparam int STQ_TIMER_SLOTS = 16;
  localparam int STQ_MAX_SLOTS   = 64;
  localparam int STQ_IDX_MAX_W   = $clog2(STQ_MAX_SLOTS);

  localparam int OPCODE_W   = 2;
  localparam int TIMER_ID_W = 4;
  localparam int DELAY_W    = 31;
  localparam int KIND_W     = 3;
  localparam int TIME_W     = 32;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK   = 2'd0,
    OP_START  = 2'd1,
    OP_CANCEL = 2'd2,
    OP_TAKEN  = 2'd3
  } opcode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACCEPTED  = 3'd0,
    KIND_REJECTED  = 3'd1,
    KIND_FIRED     = 3'd2,
    KIND_CANCELLED = 3'd3,
    KIND_TICKDONE  = 3'd4,
    KIND_TAKEN     = 3'd5
  } kind_t;

  typedef struct packed {
    logic                     enq;
    logic                     deq;
    logic                     set_pend;
    logic                     clr_pend;
    logic [STQ_IDX_MAX_W-1:0] slot;
    logic [STQ_IDX_MAX_W-1:0] rank;
    logic [TIME_W-1:0]        deadline;
  } slot_cmd_t;

endpackage

// ===== hw/rtl/stq_ifs.sv =====
// Valid/ready channel interfaces for request and result items.
interface stq_req_if;
  import stq_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [OPCODE_W-1:0]   opcode;
  logic [TIMER_ID_W-1:0] timer_id;
  logic [DELAY_W-1:0]    wait_ticks;

  modport source (output valid, output opcode, output timer_id, output wait_ticks,
                  input ready);
  modport sink (input valid, input opcode, input timer_id, input wait_ticks,
                output ready);
endinterface

interface stq_rsp_if;
  import stq_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [KIND_W-1:0]     kind;
  logic [TIMER_ID_W-1:0] timer_id_res;
  logic [TIME_W-1:0]     now_ms;
  logic                  last;

  modport source (output valid, output kind, output timer_id_res, output now_ms, output last,
                  input ready);
  modport sink (input valid, input kind, input timer_id_res, input now_ms, input last,
                output ready);
endinterface

// ===== hw/rtl/stq_alu.sv =====
// Shared 32-bit add/subtract unit with wrap-aware compare flags.
module stq_alu (
  input  logic [stq_pkg::TIME_W-1:0] a,
  input  logic [stq_pkg::TIME_W-1:0] b,
  input  logic                       sub,
  output logic [stq_pkg::TIME_W-1:0] sum,
  output logic                       zero,
  output logic                       later
);
  import stq_pkg::*;

  assign sum   = sub ? (a - b) : (a + b);
  assign zero  = (sum == '0);
  assign later = !zero && !sum[TIME_W-1];

endmodule

// ===== hw/rtl/stq_slots.sv =====
// Timer slot state: busy and pending flags, queue ranks and the deadline memory.
module stq_slots #(
  parameter int TIMER_SLOTS = stq_pkg::STQ_TIMER_SLOTS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  stq_pkg::slot_cmd_t             cmd,
  input  logic [$clog2(TIMER_SLOTS)-1:0] look_idx,
  input  logic [$clog2(TIMER_SLOTS)-1:0] rd_addr,
  output logic [stq_pkg::TIME_W-1:0]     rd_data,
  output logic                           look_busy,
  output logic                           look_pend,
  output logic [$clog2(TIMER_SLOTS)-1:0] look_rank,
  output logic [$clog2(TIMER_SLOTS)-1:0] head_idx,
  output logic                           head_found,
  output logic [$clog2(TIMER_SLOTS+1)-1:0] armed,
  output logic [TIMER_SLOTS-1:0]         busy_vec,
  output logic [TIMER_SLOTS-1:0]         pend_vec
);
  import stq_pkg::*;

  localparam int IW = $clog2(TIMER_SLOTS);

  logic [TIMER_SLOTS-1:0] busy;
  logic [TIMER_SLOTS-1:0] pend;
  logic [IW-1:0]          rank [TIMER_SLOTS];
  logic [TIME_W-1:0]      mem  [TIMER_SLOTS];
  logic [IW-1:0]          cmd_slot;
  logic [IW-1:0]          cmd_rank;

  assign cmd_slot = IW'(cmd.slot);
  assign cmd_rank = IW'(cmd.rank);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= '0;
      pend  <= '0;
      armed <= '0;
    end else begin
      for (int s = 0; s < TIMER_SLOTS; s++) begin
        if (IW'(s) == cmd_slot) begin
          if (cmd.enq) begin
            busy[s] <= 1'b1;
          end
          if (cmd.deq) begin
            busy[s] <= 1'b0;
          end
          if (cmd.set_pend) begin
            pend[s] <= 1'b1;
          end
          if (cmd.clr_pend) begin
            pend[s] <= 1'b0;
          end
        end
      end
      if (cmd.enq) begin
        armed <= armed + 1'b1;
      end else if (cmd.deq && armed != '0) begin
        armed <= armed - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < TIMER_SLOTS; s++) begin
      if (cmd.enq) begin
        if (IW'(s) == cmd_slot) begin
          rank[s] <= cmd_rank;
        end else if (busy[s] && rank[s] >= cmd_rank) begin
          rank[s] <= IW'(rank[s] + 1'b1);
        end
      end else if (cmd.deq && busy[s] && IW'(s) != cmd_slot && rank[s] > cmd_rank) begin
        rank[s] <= IW'(rank[s] - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.enq) begin
      mem[cmd_slot] <= cmd.deadline;
    end
    rd_data <= mem[rd_addr];
  end

  // The queue head is the one busy slot that holds rank zero.
  always_comb begin
    head_idx   = '0;
    head_found = 1'b0;
    for (int s = 0; s < TIMER_SLOTS; s++) begin
      if (busy[s] && rank[s] == '0) begin
        head_idx   = head_idx | IW'(s);
        head_found = 1'b1;
      end
    end
  end

  assign look_busy = busy[look_idx];
  assign look_pend = pend[look_idx];
  assign look_rank = rank[look_idx];
  assign busy_vec  = busy;
  assign pend_vec  = pend;

endmodule

// ===== hw/rtl/sorted_timer_queue_unit.sv =====
// Top level of the sorted timer queue: sequencer, shared unit and result register.
//
//   channel | role   | payload
//   --------+--------+------------------------------------------
//   req     | sink   | opcode, timer_id, wait_ticks
//   rsp     | source | kind, timer_id_res, now_ms, last
//
// A start that queues a timer runs a deadline scan through the shared
// subtractor, one slot per cycle, before it inserts the timer.
// A tick advances the time, then checks the queue head again after each
// fired timer; a zero-delay start emits its acceptance and then its expiry.
// Synchronous reset clears the counter, the slot flags and the queue.
// Each result waits in the output register until taken; a stalled result
// holds the sequencer, and req is ready only between items.
module sorted_timer_queue_unit #(
  parameter int TIMER_SLOTS = stq_pkg::STQ_TIMER_SLOTS
) (
  input logic        clk,
  input logic        rst,
  stq_req_if.sink    req,
  stq_rsp_if.source  rsp
);
  import stq_pkg::*;

  localparam int IW = $clog2(TIMER_SLOTS);
  localparam int AW = $clog2(TIMER_SLOTS + 1);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_EXEC     = 10'b0000000010,
    S_FIRE     = 10'b0000000100,
    S_ADD      = 10'b0000001000,
    S_SCAN     = 10'b0000010000,
    S_SCAN_END = 10'b0000100000,
    S_INSERT   = 10'b0001000000,
    S_HEAD     = 10'b0010000000,
    S_HEAD_CMP = 10'b0100000000,
    S_EMIT     = 10'b1000000000
  } state_t;

  state_t                state;
  state_t                em_ret;
  logic [OPCODE_W-1:0]   op;
  logic [TIMER_ID_W-1:0] id;
  logic [DELAY_W-1:0]    delay;
  logic [TIME_W-1:0]     dl;
  logic [TIME_W-1:0]     now;
  logic [IW-1:0]         pos;
  logic [IW-1:0]         scan_idx;
  logic [IW-1:0]         cmp_idx;
  logic                  cmp_vld;
  logic                  head_ok;
  kind_t                 em_kind;
  logic [TIMER_ID_W-1:0] em_id;
  logic                  em_last;
  logic                  out_valid;
  kind_t                 out_kind;
  logic [TIMER_ID_W-1:0] out_id;
  logic [TIME_W-1:0]     out_now;
  logic                  out_last;

  slot_cmd_t             cmd;
  logic [IW-1:0]         id_slot;
  logic                  id_ok;
  logic [IW-1:0]         look_idx;
  logic [IW-1:0]         rd_addr;
  logic [TIME_W-1:0]     rd_data;
  logic                  look_busy;
  logic                  look_pend;
  logic [IW-1:0]         look_rank;
  logic [IW-1:0]         head_idx;
  logic                  head_found;
  logic [AW-1:0]         armed;
  logic [TIMER_SLOTS-1:0] busy_vec;
  logic [TIMER_SLOTS-1:0] pend_vec;
  logic [TIME_W-1:0]     alu_a;
  logic [TIME_W-1:0]     alu_b;
  logic                  alu_sub;
  logic [TIME_W-1:0]     alu_sum;
  logic                  alu_zero;
  logic                  alu_later;
  logic                  later_hit;

  stq_slots #(.TIMER_SLOTS(TIMER_SLOTS)) u_slots (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .look_idx   (look_idx),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .look_busy  (look_busy),
    .look_pend  (look_pend),
    .look_rank  (look_rank),
    .head_idx   (head_idx),
    .head_found (head_found),
    .armed      (armed),
    .busy_vec   (busy_vec),
    .pend_vec   (pend_vec)
  );

  stq_alu u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .sub   (alu_sub),
    .sum   (alu_sum),
    .zero  (alu_zero),
    .later (alu_later)
  );

  assign id_slot  = IW'(id);
  assign id_ok    = (int'(id) < TIMER_SLOTS);
  assign look_idx = (state == S_SCAN || state == S_SCAN_END) ? cmp_idx : id_slot;
  assign rd_addr  = (state == S_HEAD) ? head_idx : scan_idx;

  // A queued timer that expires later than the new deadline marks the insert position.
  assign later_hit = cmp_vld && look_busy && alu_later && (look_rank < pos);

  always_comb begin
    case (state)
      S_EXEC: begin
        alu_a   = now;
        alu_b   = TIME_W'(1);
        alu_sub = 1'b0;
      end
      S_ADD: begin
        alu_a   = now;
        alu_b   = {1'b0, delay};
        alu_sub = 1'b0;
      end
      S_HEAD_CMP: begin
        alu_a   = rd_data;
        alu_b   = now;
        alu_sub = 1'b1;
      end
      default: begin
        alu_a   = rd_data;
        alu_b   = dl;
        alu_sub = 1'b1;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      S_EXEC: begin
        cmd.slot = STQ_IDX_MAX_W'(id_slot);
        cmd.rank = STQ_IDX_MAX_W'(look_rank);
        if (op != OP_TICK && id_ok) begin
          case (op)
            OP_START: begin
              cmd.set_pend = !look_busy && !look_pend && delay == '0;
            end
            OP_CANCEL: begin
              cmd.deq      = look_busy;
              cmd.clr_pend = !look_busy;
            end
            default: begin
              cmd.clr_pend = 1'b1;
            end
          endcase
        end
      end
      S_INSERT: begin
        cmd.enq      = 1'b1;
        cmd.slot     = STQ_IDX_MAX_W'(id_slot);
        cmd.rank     = STQ_IDX_MAX_W'(pos);
        cmd.deadline = dl;
      end
      S_HEAD_CMP: begin
        cmd.deq      = head_ok && alu_zero;
        cmd.set_pend = head_ok && alu_zero;
        cmd.slot     = STQ_IDX_MAX_W'(head_idx);
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      now       <= '0;
      cmp_vld   <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            op    <= req.opcode;
            id    <= req.timer_id;
            delay <= req.wait_ticks;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          em_id <= id;
          if (op == OP_TICK) begin
            now   <= alu_sum;
            state <= S_HEAD;
          end else if (!id_ok) begin
            em_kind <= KIND_REJECTED;
            em_last <= 1'b1;
            state   <= S_EMIT;
          end else begin
            case (op)
              OP_START: begin
                if (look_busy || look_pend) begin
                  em_kind <= KIND_REJECTED;
                  em_last <= 1'b1;
                  state   <= S_EMIT;
                end else if (delay == '0) begin
                  em_kind <= KIND_ACCEPTED;
                  em_last <= 1'b0;
                  em_ret  <= S_FIRE;
                  state   <= S_EMIT;
                end else begin
                  state <= S_ADD;
                end
              end
              OP_CANCEL: begin
                em_kind <= KIND_CANCELLED;
                em_last <= 1'b1;
                state   <= S_EMIT;
              end
              default: begin
                em_kind <= KIND_TAKEN;
                em_last <= 1'b1;
                state   <= S_EMIT;
              end
            endcase
          end
        end
        S_FIRE: begin
          em_kind <= KIND_FIRED;
          em_id   <= id;
          em_last <= 1'b1;
          state   <= S_EMIT;
        end
        S_ADD: begin
          dl       <= alu_sum;
          pos      <= IW'(armed);
          scan_idx <= '0;
          cmp_vld  <= 1'b0;
          state    <= S_SCAN;
        end
        S_SCAN: begin
          cmp_vld  <= 1'b1;
          cmp_idx  <= scan_idx;
          scan_idx <= IW'(scan_idx + 1'b1);
          if (later_hit) begin
            pos <= look_rank;
          end
          if (scan_idx == IW'(TIMER_SLOTS - 1)) begin
            state <= S_SCAN_END;
          end
        end
        S_SCAN_END: begin
          if (later_hit) begin
            pos <= look_rank;
          end
          cmp_vld <= 1'b0;
          state   <= S_INSERT;
        end
        S_INSERT: begin
          em_kind <= KIND_ACCEPTED;
          em_id   <= id;
          em_last <= 1'b1;
          state   <= S_EMIT;
        end
        S_HEAD: begin
          head_ok <= head_found;
          state   <= S_HEAD_CMP;
        end
        S_HEAD_CMP: begin
          state <= S_EMIT;
          if (head_ok && alu_zero) begin
            em_kind <= KIND_FIRED;
            em_id   <= TIMER_ID_W'(head_idx);
            em_last <= 1'b0;
            em_ret  <= S_HEAD;
          end else begin
            em_kind <= KIND_TICKDONE;
            em_id   <= '0;
            em_last <= 1'b1;
          end
        end
        S_EMIT: begin
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out_kind  <= em_kind;
            out_id    <= em_id;
            out_now   <= now;
            out_last  <= em_last;
            state     <= em_last ? S_IDLE : em_ret;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready        = (state == S_IDLE);
  assign rsp.valid        = out_valid;
  assign rsp.kind         = out_kind;
  assign rsp.timer_id_res = out_id;
  assign rsp.now_ms       = out_now;
  assign rsp.last         = out_last;

`ifndef NO_ASSERTIONS
  a_busy_not_pending: assert property (@(posedge clk) disable iff (rst)
    (busy_vec & pend_vec) == '0)
    else $error("A timer slot is both queued and pending.");

  a_armed_matches_busy: assert property (@(posedge clk) disable iff (rst)
    $countones(busy_vec) == int'(armed))
    else $error("Queued timer count disagrees with busy flags.");

  a_head_needs_armed: assert property (@(posedge clk) disable iff (rst)
    (armed == '0) |-> !head_found)
    else $error("Queue head found while no timer is queued.");
`endif

endmodule

// ===== dv/stq_result_monitor.sv =====
`timescale 1ns / 1ps
// Result monitor for the sorted timer queue: predicts the results of each request and checks them.
module stq_result_monitor (
  input  logic clk,
  input  logic rst,
  stq_req_if   req,
  stq_rsp_if   rsp,
  output int   fail_count,
  output int   outstanding,
  output int   results_checked,
  output int   expiries_seen
);
  import stq_pkg::*;

  localparam int SLOTS = STQ_TIMER_SLOTS;

  typedef struct packed {
    kind_t                 kind;
    logic [TIMER_ID_W-1:0] id;
    logic [TIME_W-1:0]     now;
    logic                  last;
  } timer_result_t;

  timer_result_t     expected_results[$];
  int                deadline_order[$];
  logic [TIME_W-1:0] tick_count;
  logic [TIME_W-1:0] deadline_ms[SLOTS];
  logic              armed[SLOTS];
  logic              pending[SLOTS];

  function automatic void push_result(kind_t kind, logic [TIMER_ID_W-1:0] id);
    timer_result_t r;
    r = '{kind: kind, id: id, now: tick_count, last: 1'b0};
    expected_results.push_back(r);
  endfunction

  task automatic apply_request(opcode_t op, logic [TIMER_ID_W-1:0] id,
                               logic [DELAY_W-1:0] dly);
    int                head;
    int                pos;
    logic [TIME_W-1:0] due;
    logic [TIME_W-1:0] diff;
    case (op)
      OP_TICK: begin
        tick_count = tick_count + 1'b1;
        while (deadline_order.size() > 0 && deadline_ms[deadline_order[0]] == tick_count) begin
          head = deadline_order.pop_front();
          armed[head] = 1'b0;
          pending[head] = 1'b1;
          push_result(KIND_FIRED, TIMER_ID_W'(head));
        end
        push_result(KIND_TICKDONE, '0);
      end
      OP_START: begin
        if (armed[id] || pending[id]) begin
          push_result(KIND_REJECTED, id);
        end else if (dly == '0) begin
          pending[id] = 1'b1;
          push_result(KIND_ACCEPTED, id);
          push_result(KIND_FIRED, id);
        end else begin
          // A new timer goes behind every queued timer that is not due later, in modulo time.
          due = tick_count + TIME_W'(dly);
          pos = 0;
          while (pos < deadline_order.size()) begin
            diff = deadline_ms[deadline_order[pos]] - due;
            if (diff != '0 && !diff[TIME_W-1]) break;
            pos++;
          end
          deadline_order.insert(pos, int'(id));
          deadline_ms[id] = due;
          armed[id] = 1'b1;
          push_result(KIND_ACCEPTED, id);
        end
      end
      OP_CANCEL: begin
        if (armed[id]) begin
          for (pos = 0; pos < deadline_order.size(); pos++) begin
            if (deadline_order[pos] == int'(id)) begin
              deadline_order.delete(pos);
              break;
            end
          end
          armed[id] = 1'b0;
        end else begin
          pending[id] = 1'b0;
        end
        push_result(KIND_CANCELLED, id);
      end
      default: begin
        pending[id] = 1'b0;
        push_result(KIND_TAKEN, id);
      end
    endcase
    expected_results[expected_results.size()-1].last = 1'b1;
  endtask

  always @(posedge clk) begin : compare_results
    timer_result_t got;
    timer_result_t want;
    if (rst) begin
      tick_count = '0;
      for (int s = 0; s < SLOTS; s++) begin
        armed[s] = 1'b0;
        pending[s] = 1'b0;
      end
      deadline_order.delete();
      expected_results.delete();
      fail_count = 0;
      results_checked = 0;
      expiries_seen = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got = '{kind: kind_t'(rsp.kind), id: rsp.timer_id_res, now: rsp.now_ms,
                last: rsp.last};
        results_checked++;
        if (got.kind == KIND_FIRED) expiries_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t: result with none expected, got kind=%0d id=%0d now=%0d last=%0b",
                   $time, got.kind, got.id, got.now, got.last);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch, expected kind=%0d id=%0d now=%0d last=%0b",
                     $time, want.kind, want.id, want.now, want.last);
            $display("%0t:   actual kind=%0d id=%0d now=%0d last=%0b",
                     $time, got.kind, got.id, got.now, got.last);
            fail_count++;
          end
        end
      end
      if (req.valid && req.ready) begin
        apply_request(opcode_t'(req.opcode), req.timer_id, req.wait_ticks);
      end
    end
    outstanding = expected_results.size();
  end

endmodule

// ===== dv/sorted_timer_queue_unit_test.sv =====
`timescale 1ns / 1ps
// Top of the sorted timer queue testbench: clock, reset, request and result traffic, verdict.
module sorted_timer_queue_unit_test;
  import stq_pkg::*;

  logic clk = 1'b0;
  logic rst;
  bit   quiet_tail = 1'b0;
  int   items_sent = 0;
  int   ticks_sent = 0;
  int   fail_count;
  int   outstanding;
  int   results_checked;
  int   expiries_seen;

  stq_req_if req_ch ();
  stq_rsp_if rsp_ch ();

  sorted_timer_queue_unit DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  stq_result_monitor monitor (
    .clk             (clk),
    .rst             (rst),
    .req             (req_ch),
    .rsp             (rsp_ch),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .expiries_seen   (expiries_seen)
  );

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic logic [DELAY_W-1:0] pick_delay();
    int r;
    r = $urandom_range(0, 19);
    if (r < 3) return '0;
    if (r < 6) return DELAY_W'($urandom);
    if (r == 6) return {DELAY_W{1'b1}};
    return DELAY_W'($urandom_range(1, 12));
  endfunction

  task automatic offer_request(opcode_t op, logic [TIMER_ID_W-1:0] id,
                               logic [DELAY_W-1:0] dly);
    int gap;
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 9);
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.opcode     <= op;
    req_ch.timer_id   <= id;
    req_ch.wait_ticks <= dly;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    items_sent++;
    if (op == OP_TICK) ticks_sent++;
  endtask

  task automatic random_request();
    int                    pick;
    logic [TIMER_ID_W-1:0] id;
    pick = $urandom_range(0, 99);
    id = TIMER_ID_W'($urandom_range(0, STQ_TIMER_SLOTS - 1));
    if (pick < 40) offer_request(OP_TICK, id, DELAY_W'($urandom));
    else if (pick < 70) offer_request(OP_START, id, pick_delay());
    else if (pick < 80) offer_request(OP_CANCEL, id, DELAY_W'($urandom));
    else offer_request(OP_TAKEN, id, DELAY_W'($urandom));
  endtask

  // Arms every slot with one common deadline so that a single tick fires the whole queue.
  task automatic fill_all_slots();
    logic [DELAY_W-1:0] dly;
    dly = DELAY_W'($urandom_range(1, 4));
    for (int s = 0; s < STQ_TIMER_SLOTS; s++) begin
      offer_request(OP_CANCEL, TIMER_ID_W'(s), DELAY_W'($urandom));
      offer_request(OP_START, TIMER_ID_W'(s), dly);
    end
    repeat (dly) offer_request(OP_TICK, TIMER_ID_W'($urandom), DELAY_W'($urandom));
  endtask

  initial begin : result_sink
    int cycle_count;
    int burst;
    bit long_hold_done;
    cycle_count = 0;
    long_hold_done = 1'b0;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!long_hold_done && cycle_count >= 150) begin
        long_hold_done = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
        cycle_count += 300;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 9);
        rsp_ch.ready <= 1'b0;
        repeat (burst) @(posedge clk);
        cycle_count += burst;
      end else begin
        rsp_ch.ready <= 1'b1;
        @(posedge clk);
        cycle_count++;
      end
    end
  end

  initial begin : request_source
    int fills_done;
    fills_done = 0;
    rst               <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.opcode     <= OP_TICK;
    req_ch.timer_id   <= '0;
    req_ch.wait_ticks <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    offer_request(OP_TICK, '0, '0);
    offer_request(OP_START, 4'd0, '0);
    offer_request(OP_START, 4'd0, DELAY_W'(5));
    offer_request(OP_TAKEN, 4'd0, '0);
    offer_request(OP_START, 4'd15, DELAY_W'(2));
    offer_request(OP_START, 4'd1, DELAY_W'(2));
    offer_request(OP_START, 4'd2, DELAY_W'(1));
    offer_request(OP_START, 4'd3, {DELAY_W{1'b1}});
    offer_request(OP_START, 4'd15, DELAY_W'(3));
    offer_request(OP_TICK, 4'd15, {DELAY_W{1'b1}});
    offer_request(OP_TICK, '0, '0);
    offer_request(OP_START, 4'd1, DELAY_W'(1));
    offer_request(OP_CANCEL, 4'd3, '0);
    offer_request(OP_CANCEL, 4'd15, '0);
    offer_request(OP_CANCEL, 4'd4, '0);
    offer_request(OP_TAKEN, 4'd1, '0);
    offer_request(OP_TAKEN, 4'd5, '0);
    offer_request(OP_START, 4'd4, DELAY_W'(1));
    offer_request(OP_START, 4'd5, DELAY_W'(31'h4000_0000));
    offer_request(OP_START, 4'd6, DELAY_W'(1));
    offer_request(OP_START, 4'd7, DELAY_W'(31'h5555_5555));
    offer_request(OP_TICK, '0, '0);
    offer_request(OP_CANCEL, 4'd5, '0);
    offer_request(OP_CANCEL, 4'd7, '0);
    offer_request(OP_TICK, '0, '0);

    while (items_sent < 250) begin
      if (fills_done < 2 && items_sent >= 90 + 70 * fills_done) begin
        fill_all_slots();
        fills_done++;
      end else begin
        random_request();
      end
      if (items_sent >= 200) quiet_tail = 1'b1;
    end
    req_ch.valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (2 * (STQ_TIMER_SLOTS + 5)) @(posedge clk);

    $display("Covered %0d request items, %0d of them ticks, with two full-queue expiries.",
             items_sent, ticks_sent);
    $display("Checked %0d result items, %0d of them timer expiries.",
             results_checked, expiries_seen);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
